FILE: rtl/ils_pkg.sv
// Shared constants and types for the indexed list store.
package ils_pkg;

  // Number of element slots in the store.
  localparam int DEPTH = 16;

  // Fixed field widths of the request and result transactions.
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 5;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;

  // Derived widths: element count, slot index and the common compare width.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd2;
  localparam logic [FUNC_W-1:0] OP_ERASE  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // perform the captured operation and register the result
  } ils_cmd_t;

endpackage

FILE: rtl/ils_ctrl.sv
// Controller state machine that sequences one transaction at a time.
module ils_ctrl
  import ils_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output ils_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = valid_r;

endmodule

FILE: rtl/ils_datapath.sv
// Datapath: request registers, the element register row, the count and result registers.
module ils_datapath
  import ils_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  ils_cmd_t                   cmd,
  input  logic        [FUNC_W-1:0]   in_func,
  input  logic        [POS_W-1:0]    in_position,
  input  logic signed [WORD_W-1:0]   in_word_in,
  output logic signed [WORD_W-1:0]   out_word_out,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [OUT_CNT_W-1:0] out_count,
  output logic                       out_is_empty
);

  logic        [FUNC_W-1:0]    func_r;
  logic        [POS_W-1:0]     pos_r;
  logic signed [WORD_W-1:0]    word_r;
  logic        [CNT_W-1:0]     held_r, held_nxt;
  logic signed [WORD_W-1:0]    elem_r [DEPTH];
  logic signed [WORD_W-1:0]    word_out_r, word_out_nxt;
  logic        [STATUS_W-1:0]  status_r, status_nxt;
  logic        [OUT_CNT_W-1:0] count_r;
  logic                        empty_r;

  logic [CMP_W-1:0] pos_x, held_x;
  logic             in_range, ins_range, full;
  logic             do_write, do_insert, do_erase;

  assign pos_x     = CMP_W'(pos_r);
  assign held_x    = CMP_W'(held_r);
  // Since the count never exceeds the depth, an index below the count is a valid slot.
  assign in_range  = (pos_x < held_x);
  assign ins_range = (pos_x <= held_x);
  assign full      = (held_r == CNT_W'(DEPTH));

  always_comb begin
    held_nxt     = held_r;
    word_out_nxt = '0;
    status_nxt   = ST_DONE;
    do_write     = 1'b0;
    do_insert    = 1'b0;
    do_erase     = 1'b0;
    unique case (func_r)
      OP_READ: begin
        if (in_range) begin
          word_out_nxt = elem_r[pos_x[IDX_W-1:0]];
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (in_range) begin
          do_write = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_INSERT: begin
        priority if (!ins_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_insert = 1'b1;
          held_nxt  = held_r + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (in_range) begin
          do_erase = 1'b1;
          held_nxt = held_r - CNT_W'(1);
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.exec) begin
      held_r <= held_nxt;
    end
  end

  // Each slot takes its new value from itself, a neighbor or the request word.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if ((do_write || do_insert) && (CMP_W'(i) == pos_x)) begin
          elem_r[IDX_W'(i)] <= word_r;
        end else if (do_insert && (CMP_W'(i) > pos_x) && (CMP_W'(i) <= held_x)) begin
          if (i > 0) begin
            elem_r[IDX_W'(i)] <= elem_r[IDX_W'(i - 1)];
          end
        end else if (do_erase && (CMP_W'(i) >= pos_x) && (CMP_W'(i + 1) < held_x)) begin
          if (i < DEPTH - 1) begin
            elem_r[IDX_W'(i)] <= elem_r[IDX_W'(i + 1)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      word_out_r <= word_out_nxt;
      status_r   <= status_nxt;
      count_r    <= OUT_CNT_W'(held_nxt);
      empty_r    <= (held_nxt == '0);
    end
  end

  assign out_word_out = word_out_r;
  assign out_status   = status_r;
  assign out_count    = count_r;
  assign out_is_empty = empty_r;

endmodule

FILE: rtl/indexed_list_store_top.sv
// Top level of the indexed list store: controller and datapath joined by commands.
//
// The block keeps an ordered list of signed 32-bit words addressed by position,
// up to DEPTH of them, in a row of registers that shifts every element at once.
// A request transaction is taken at a rising edge where start is high and busy
// is low; it carries the operation (read, write, insert, erase), the position
// and the word for write or insert.
// The operation executes in the cycle after acceptance, and the result appears
// on the out_ ports in the following cycle, marked by a one-cycle out_valid
// strobe. Busy is high for the single execute cycle, so a new request can be
// taken in the same cycle that the previous result is shown. Each request
// passes through the request register stage and then the execute stage.
// The receiver cannot stall; out_valid marks each result for exactly one
// cycle, and the out_ ports hold it until the next operation executes.
// A synchronous reset (rst_n low) empties the list and returns the controller
// to idle. Element contents are not cleared; only slots below the count are
// ever read, and those have always been written.
// An out-of-range position reports status 1 and a full insert status 2;
// neither changes the list.
module indexed_list_store_top
  import ils_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic        [FUNC_W-1:0]    in_func,
  input  logic        [POS_W-1:0]     in_position,
  input  logic signed [WORD_W-1:0]    in_word_in,
  output logic                        out_valid,
  output logic signed [WORD_W-1:0]    out_word_out,
  output logic        [STATUS_W-1:0]  out_status,
  output logic        [OUT_CNT_W-1:0] out_count,
  output logic                        out_is_empty
);

  ils_cmd_t cmd;

  // The controller gates start with its own idle state, so load only fires
  // on an accepted transaction.
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ils_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_empty (out_is_empty)
  );

endmodule
